// ----- hw/rtl/plr_pkg.sv -----
// Shared types for the polyline route length block.
`timescale 1ns / 1ps

package plr_pkg;

    typedef struct packed {
        logic busy;
        logic done;
    } seg_status_t;

endpackage

// ----- hw/rtl/polyline_route_length.sv -----
// Top level: per-route Euclidean polyline length with saturating sum.
`timescale 1ns / 1ps
// A point with a predecessor in its route passes through the segment step (bit-serial
// squaring, then square root in plr_seg) before the finish step; a first point goes straight to finish.
// A new point is taken only in the idle step, after the last point has finished;
// the bit-serial squaring and square root in plr_seg set the pace.
// A route end waits in the finish step while the previous total is still pending.
// Reset: rst_n clears all state; route counter, sum and flags start at zero.

module polyline_route_length #(
    parameter int COORD_BITS       = 24,
    parameter int SUM_BITS         = 40,
    parameter int ROUTE_COUNT_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [COORD_BITS-1:0]       pos_x,
    input  logic [COORD_BITS-1:0]       pos_y,
    input  logic                        route_last,
    input  logic                        stream_last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ROUTE_COUNT_BITS-1:0] route_number,
    output logic [SUM_BITS-1:0]         route_length,
    output logic                        length_saturated
);

    localparam int SEG_BITS = COORD_BITS + 1;
    localparam int ADD_BITS = ((SUM_BITS > SEG_BITS) ? SUM_BITS : SEG_BITS) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEG,
        S_FIN
    } top_state_t;

    top_state_t                  state_reg;
    logic [COORD_BITS-1:0]       prev_x_reg;
    logic [COORD_BITS-1:0]       prev_y_reg;
    logic                        have_prev_reg;
    logic                        add_reg;
    logic                        end_reg;
    logic                        stream_reg;
    logic [SUM_BITS-1:0]         sum_reg;
    logic                        clip_reg;
    logic [ROUTE_COUNT_BITS-1:0] count_reg;
    logic                        out_valid_reg;
    logic [ROUTE_COUNT_BITS-1:0] route_number_reg;
    logic [SUM_BITS-1:0]         route_length_reg;
    logic                        length_saturated_reg;

    logic                        accept;
    logic                        seg_start;
    logic [COORD_BITS:0]         dx_diff;
    logic [COORD_BITS:0]         dy_diff;
    logic [COORD_BITS:0]         dx_neg;
    logic [COORD_BITS:0]         dy_neg;
    logic [COORD_BITS-1:0]       ax;
    logic [COORD_BITS-1:0]       ay;
    plr_pkg::seg_status_t        seg_stat;
    logic [SEG_BITS-1:0]         seg;
    logic [ADD_BITS-1:0]         total;
    logic                        overflow;
    logic [SUM_BITS-1:0]         sum_next;
    logic                        clip_next;
    logic                        slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign seg_start = accept && have_prev_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        dx_diff   = {pos_x[COORD_BITS-1], pos_x} - {prev_x_reg[COORD_BITS-1], prev_x_reg};
        dy_diff   = {pos_y[COORD_BITS-1], pos_y} - {prev_y_reg[COORD_BITS-1], prev_y_reg};
        dx_neg    = (~dx_diff) + (COORD_BITS + 1)'(1);
        dy_neg    = (~dy_diff) + (COORD_BITS + 1)'(1);
        ax        = dx_diff[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx_diff[COORD_BITS-1:0];
        ay        = dy_diff[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy_diff[COORD_BITS-1:0];
        total     = ADD_BITS'(sum_reg) + ADD_BITS'(seg);
        overflow  = |total[ADD_BITS-1:SUM_BITS];
        if (!add_reg)
        begin
            sum_next  = sum_reg;
            clip_next = clip_reg;
        end
        else if (overflow)
        begin
            sum_next  = '1;
            clip_next = 1'b1;
        end
        else
        begin
            sum_next  = total[SUM_BITS-1:0];
            clip_next = clip_reg;
        end
    end

    plr_seg #(
        .COORD_BITS (COORD_BITS)
    ) u_seg (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (seg_start),
        .ax     (ax),
        .ay     (ay),
        .status (seg_stat),
        .seg    (seg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            prev_x_reg           <= '0;
            prev_y_reg           <= '0;
            have_prev_reg        <= 1'b0;
            add_reg              <= 1'b0;
            end_reg              <= 1'b0;
            stream_reg           <= 1'b0;
            sum_reg              <= '0;
            clip_reg             <= 1'b0;
            count_reg            <= '0;
            out_valid_reg        <= 1'b0;
            route_number_reg     <= '0;
            route_length_reg     <= '0;
            length_saturated_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !((state_reg == S_FIN) && end_reg))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        prev_x_reg    <= pos_x;
                        prev_y_reg    <= pos_y;
                        have_prev_reg <= 1'b1;
                        add_reg       <= have_prev_reg;
                        end_reg       <= route_last || stream_last;
                        stream_reg    <= stream_last;
                        state_reg     <= have_prev_reg ? S_SEG : S_FIN;
                    end
                end
                S_SEG:
                begin
                    if (seg_stat.done)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!end_reg)
                    begin
                        sum_reg   <= sum_next;
                        clip_reg  <= clip_next;
                        state_reg <= S_IDLE;
                    end
                    else if (slot_free)
                    begin
                        out_valid_reg        <= 1'b1;
                        route_number_reg     <= count_reg;
                        route_length_reg     <= sum_next;
                        length_saturated_reg <= clip_next;
                        sum_reg              <= '0;
                        clip_reg             <= 1'b0;
                        have_prev_reg        <= 1'b0;
                        count_reg            <= stream_reg ? '0 : count_reg + 1'b1;
                        state_reg            <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign route_number     = route_number_reg;
    assign route_length     = route_length_reg;
    assign length_saturated = length_saturated_reg;

`ifndef SYNTHESIS
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result appeared outside finish step");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && length_saturated_reg |-> route_length_reg == {SUM_BITS{1'b1}})
        else $error("saturated result not at maximum");

    a_clip_holds: assert property (@(posedge clk) disable iff (!rst_n)
        clip_reg |-> sum_reg == {SUM_BITS{1'b1}})
        else $error("clipped sum left its maximum");

    a_seg_active: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEG |-> seg_stat.busy || seg_stat.done)
        else $error("waiting on idle segment unit");

    a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !seg_stat.busy)
        else $error("transfer possible while segment unit busy");
`endif

endmodule

// ----- hw/rtl/plr_seg.sv -----
// Bit-serial segment length unit: shift-add squares, then a restoring square root.
`timescale 1ns / 1ps

module plr_seg #(
    parameter int COORD_BITS = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [COORD_BITS-1:0]   ax,
    input  logic [COORD_BITS-1:0]   ay,
    output plr_pkg::seg_status_t    status,
    output logic [COORD_BITS:0]     seg
);

    localparam int SEG_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * COORD_BITS;
    localparam int ACC_BITS  = PROD_BITS + 1;
    localparam int RAD_BITS  = PROD_BITS + 2;
    localparam int REM_BITS  = COORD_BITS + 2;
    localparam int CAND_BITS = COORD_BITS + 4;
    localparam int CNT_BITS  = $clog2(COORD_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROOT,
        ST_DONE
    } seg_state_t;

    seg_state_t            state_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [COORD_BITS-1:0] mx_reg;
    logic [COORD_BITS-1:0] my_reg;
    logic [PROD_BITS-1:0]  cx_reg;
    logic [PROD_BITS-1:0]  cy_reg;
    logic [ACC_BITS-1:0]   acc_reg;
    logic [RAD_BITS-1:0]   rad_reg;
    logic [REM_BITS-1:0]   rem_reg;
    logic [SEG_BITS-1:0]   root_reg;

    logic [PROD_BITS-1:0]  part_x;
    logic [PROD_BITS-1:0]  part_y;
    logic [ACC_BITS-1:0]   acc_next;
    logic [CAND_BITS-1:0]  cand;
    logic [CAND_BITS-1:0]  trial;
    logic [CAND_BITS-1:0]  diff;
    logic                  fits;
    logic [REM_BITS-1:0]   rem_next;
    logic [SEG_BITS-1:0]   root_next;

    always_comb
    begin
        part_x    = mx_reg[0] ? cx_reg : '0;
        part_y    = my_reg[0] ? cy_reg : '0;
        acc_next  = acc_reg + ACC_BITS'(part_x) + ACC_BITS'(part_y);
        cand      = {rem_reg, rad_reg[RAD_BITS-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = cand - trial;
        fits      = (cand >= trial);
        rem_next  = fits ? diff[REM_BITS-1:0] : cand[REM_BITS-1:0];
        root_next = {root_reg[SEG_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            mx_reg    <= '0;
            my_reg    <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            acc_reg   <= '0;
            rad_reg   <= '0;
            rem_reg   <= '0;
            root_reg  <= '0;
        end
        else if (start)
        begin
            state_reg <= ST_MUL;
            cnt_reg   <= CNT_BITS'(COORD_BITS - 1);
            mx_reg    <= ax;
            my_reg    <= ay;
            cx_reg    <= PROD_BITS'(ax);
            cy_reg    <= PROD_BITS'(ay);
            acc_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_MUL:
                begin
                    acc_reg <= acc_next;
                    mx_reg  <= mx_reg >> 1;
                    my_reg  <= my_reg >> 1;
                    cx_reg  <= cx_reg << 1;
                    cy_reg  <= cy_reg << 1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_ROOT;
                        cnt_reg   <= CNT_BITS'(COORD_BITS);
                        rad_reg   <= {1'b0, acc_next};
                        rem_reg   <= '0;
                        root_reg  <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_ROOT:
                begin
                    rem_reg  <= rem_next;
                    root_reg <= root_next;
                    rad_reg  <= rad_reg << 2;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= state_reg;
                end
            endcase
        end
    end

    assign status.busy = (state_reg == ST_MUL) || (state_reg == ST_ROOT);
    assign status.done = (state_reg == ST_DONE);
    assign seg         = root_reg;

endmodule

// ----- tb/route_length_checker.sv -----
// Checker for polyline_route_length: predicts route totals and compares every result transfer.
`timescale 1ns / 1ps

module route_length_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [23:0] pos_x,
    input  logic [23:0] pos_y,
    input  logic        route_last,
    input  logic        stream_last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] route_number,
    input  logic [39:0] route_length,
    input  logic        length_saturated,
    output int          fail_count,
    output int          pending,
    output int          result_count
);

    localparam int CW = 24;
    localparam int SW = 40;
    localparam int NW = 16;

    typedef struct packed {
        logic [NW-1:0] number;
        logic [SW-1:0] length;
        logic          saturated;
    } route_total_t;

    route_total_t  expected_totals[$];
    route_total_t  want;

    logic [CW-1:0] last_x;
    logic [CW-1:0] last_y;
    logic          have_last;
    logic [SW-1:0] length_acc;
    logic          acc_clipped;
    logic [NW-1:0] route_idx;

    function automatic logic [31:0] int_sqrt(input logic [63:0] v);
        logic [31:0] r;
        logic [63:0] c;
        r = '0;
        for (int i = 31; i >= 0; i--)
        begin
            c = {32'd0, r | (32'd1 << i)};
            if (c * c <= v)
                r = r | (32'd1 << i);
        end
        return r;
    endfunction

    function automatic logic [63:0] axis_square(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic signed [CW:0] d;
        logic [CW:0]        m;
        d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
        m = d[CW] ? -d : d;
        return {39'd0, m} * {39'd0, m};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        fail_count++;
        $display("[%0t] mismatch: %s got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
    endtask

    task automatic predict_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                 input logic rl, input logic sl);
        logic [31:0]  seg;
        logic [SW:0]  total;
        route_total_t res;
        if (have_last)
        begin
            seg   = int_sqrt(axis_square(x, last_x) + axis_square(y, last_y));
            total = {1'b0, length_acc} + {{(SW - 31){1'b0}}, seg};
            if (total[SW])
            begin
                length_acc  = '1;
                acc_clipped = 1'b1;
            end
            else
            begin
                length_acc = total[SW-1:0];
            end
        end
        last_x    = x;
        last_y    = y;
        have_last = 1'b1;
        if (rl || sl)
        begin
            res.number    = route_idx;
            res.length    = length_acc;
            res.saturated = acc_clipped;
            expected_totals = {expected_totals, res};
            length_acc  = '0;
            acc_clipped = 1'b0;
            have_last   = 1'b0;
            route_idx   = sl ? '0 : route_idx + 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_totals.delete();
            last_x       = '0;
            last_y       = '0;
            have_last    = 1'b0;
            length_acc   = '0;
            acc_clipped  = 1'b0;
            route_idx    = '0;
            fail_count   = 0;
            result_count = 0;
            pending     <= 0;
        end
        else
        begin
            // result transfer first: a point taken at this edge cannot be finished yet
            if (out_valid && out_ready)
            begin
                result_count++;
                if (expected_totals.size() == 0)
                begin
                    report_mismatch("result with nothing pending, route_number",
                                    64'(route_number), 64'd0);
                end
                else
                begin
                    want = expected_totals.pop_front();
                    if (route_number !== want.number)
                        report_mismatch("route_number", 64'(route_number), 64'(want.number));
                    if (route_length !== want.length)
                        report_mismatch("route_length", 64'(route_length), 64'(want.length));
                    if (length_saturated !== want.saturated)
                        report_mismatch("length_saturated", 64'(length_saturated),
                                        64'(want.saturated));
                end
            end
            if (in_valid && in_ready)
                predict_point(pos_x, pos_y, route_last, stream_last);
            pending <= expected_totals.size();
        end
    end

endmodule

// ----- tb/tb_polyline_route_length.sv -----
// Testbench top for polyline_route_length: point stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module tb_polyline_route_length;

    localparam logic [23:0] COORD_MAX    = 24'h7FFFFF;
    localparam logic [23:0] COORD_MIN    = 24'h800000;
    localparam int          DRAIN_CYCLES = 64;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        out_ready   = 1'b0;
    logic [23:0] pos_x       = '0;
    logic [23:0] pos_y       = '0;
    logic        route_last  = 1'b0;
    logic        stream_last = 1'b0;

    logic        in_ready;
    logic        out_valid;
    logic [15:0] route_number;
    logic [39:0] route_length;
    logic        length_saturated;

    int          fail_count;
    int          pending;
    int          result_count;
    int          items_sent   = 0;
    int          src_idle_pct = 13;
    int          dst_idle_pct = 88;
    logic [23:0] walk_x       = '0;
    logic [23:0] walk_y       = '0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    polyline_route_length i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .route_last       (route_last),
        .stream_last      (stream_last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .route_number     (route_number),
        .route_length     (route_length),
        .length_saturated (length_saturated)
    );

    route_length_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .route_last       (route_last),
        .stream_last      (stream_last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .route_number     (route_number),
        .route_length     (route_length),
        .length_saturated (length_saturated),
        .fail_count       (fail_count),
        .pending          (pending),
        .result_count     (result_count)
    );

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= dst_idle_pct);

    task automatic send_point(input logic [23:0] x, input logic [23:0] y,
                              input logic rl, input logic sl);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct)
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        pos_x       <= x;
        pos_y       <= y;
        route_last  <= rl;
        stream_last <= sl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // hold off until every route total is out
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [23:0] pick_coord(input logic [23:0] near);
        case ($urandom_range(0, 5))
            0, 1:    return 24'($urandom);
            2:
            begin
                case ($urandom_range(0, 4))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return 24'd0;
                    3:       return '1;
                    default: return 24'd1;
                endcase
            end
            3, 4:    return near + 24'($urandom_range(0, 8191)) - 24'd4096;
            default: return 24'($urandom_range(0, 65535)) - 24'd32768;
        endcase
    endfunction

    task automatic random_routes(input int n);
        int   sent;
        int   len;
        logic rl;
        logic sl;
        sent = 0;
        while (sent < n)
        begin
            len = $urandom_range(1, 8);
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(9, 30);
            for (int p = 0; p < len; p++)
            begin
                walk_x = pick_coord(walk_x);
                walk_y = pick_coord(walk_y);
                rl     = (p == len - 1);
                sl     = 1'b0;
                if (rl)
                begin
                    sl = ($urandom_range(0, 14) == 0);
                    if (sl && $urandom_range(0, 1))
                        rl = 1'b0;
                end
                else if ($urandom_range(0, 199) == 0)
                begin
                    sl = 1'b1;
                end
                send_point(walk_x, walk_y, rl, sl);
                sent++;
            end
            if ($urandom_range(0, 39) == 0)
                wait_drain();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_point(24'd0, 24'd0, 1'b1, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 1'b0, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b1, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b0, 1'b0);
        send_point(COORD_MIN, COORD_MAX, 1'b1, 1'b0);
        send_point(24'd0, 24'd0, 1'b0, 1'b0);
        wait_drain();
        send_point(24'h003000, 24'h004000, 1'b0, 1'b0);
        send_point(24'h003000, 24'h004000, 1'b1, 1'b0);
        send_point(24'd1, 24'd1, 1'b0, 1'b0);
        send_point(24'd5, 24'hFFFFF9, 1'b0, 1'b1);
        send_point(24'h123456, 24'hEDCBA9, 1'b1, 1'b1);
        send_point('1, '1, 1'b0, 1'b0);
        send_point(24'd0, 24'd0, 1'b0, 1'b0);
        send_point(24'd1, 24'd1, 1'b0, 1'b0);
        send_point(24'd0, '1, 1'b1, 1'b0);
        send_point(COORD_MAX, 24'd0, 1'b0, 1'b0);
        send_point(COORD_MIN, 24'd0, 1'b1, 1'b0);
        send_point(24'd0, COORD_MIN, 1'b0, 1'b0);
        send_point(24'd0, COORD_MAX, 1'b1, 1'b0);
        wait_drain();

        random_routes(320);
        src_idle_pct = 88;
        dst_idle_pct = 13;
        random_routes(320);
        src_idle_pct = 0;
        dst_idle_pct = 0;
        random_routes(300);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d points and checked %0d route totals under varied back-pressure",
                 items_sent, result_count);
        $display("Covered single-point routes, stream ends, extreme corners and full drains");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
